@@ rtl/itrs_pkg.sv @@
// Shared types, constants and helper functions for the integer to radix string converter.
package itrs_pkg;

    typedef logic [7:0] char_t;
    typedef logic [5:0] radix_t;

    localparam radix_t RADIX_MIN   = 6'd2;
    localparam radix_t RADIX_MAX   = 6'd36;
    localparam radix_t RADIX_RESET = 6'd10;
    localparam radix_t DECIMAL_LIMIT = 6'd10;
    localparam char_t  DIGIT_ZERO    = 8'd48;
    localparam char_t  LETTER_OFFSET = 8'd87;
    localparam char_t  MINUS_SIGN    = 8'd45;

    function automatic radix_t eff_radix(input radix_t r);
        radix_t res;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        else
        begin
            res = r;
        end
        return res;
    endfunction

    function automatic char_t digit_char(input radix_t d);
        char_t res;
        if (d < DECIMAL_LIMIT)
        begin
            res = {2'b00, d} + DIGIT_ZERO;
        end
        else
        begin
            res = {2'b00, d} + LETTER_OFFSET;
        end
        return res;
    endfunction

endpackage

@@ rtl/itrs_div.sv @@
// Shift-subtract divider that produces one quotient bit per cycle.
module itrs_div
    import itrs_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] dividend,
    input  radix_t               divisor,
    output logic                 done,
    output logic [WORD_BITS-1:0] quotient,
    output radix_t               remainder
);

    localparam int CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic [WORD_BITS-1:0] quo_reg, quo_next;
    radix_t               rem_reg, rem_next;
    radix_t               dsr_reg, dsr_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [6:0] rem_sh;
    logic       ge;
    logic [6:0] rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[WORD_BITS-1]};
        ge      = (rem_sh >= {1'b0, dsr_reg});
        rem_sub = rem_sh - {1'b0, dsr_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(WORD_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[WORD_BITS-2:0], ge};
            rem_next = ge ? rem_sub[5:0] : rem_sh[5:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/itrs_digit_stack.sv @@
// Digit memory that holds the characters of one number until they are sent out.
module itrs_digit_stack
    import itrs_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  char_t                    wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output char_t                    rd_data
);

    char_t mem [DEPTH];
    char_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/int_to_radix_string.sv @@
// Each digit is produced by the shared divider; then a minus sign is sent for a negative
// value, then the digits, each fetched from the digit stack and loaded into the output register.
// Throughput: one number at a time; the next input is taken once the final character is
// in the output register. Reset (rst_n, asynchronous, active low) sets the radix to 10
// and returns the sequencer to idle with no character pending.
// Top level of the integer to radix string converter.
module int_to_radix_string
    import itrs_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,      // radix
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // character
    output logic        m_axis_tlast
);

    localparam int NW = $clog2(WORD_BITS + 1);
    localparam int AW = $clog2(WORD_BITS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_SIGN  = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_LOAD  = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    radix_t         radix_reg, radix_next;
    logic           neg_reg, neg_next;
    logic [NW-1:0]  nd_reg, nd_next;
    logic           oval_reg, oval_next;
    char_t          ochar_reg, ochar_next;
    logic           olast_reg, olast_next;

    logic signed [WORD_BITS-1:0] raw;
    logic [WORD_BITS-1:0]        mag;
    logic [NW-1:0]               nd_inc, nd_dec;
    logic                        out_free;

    logic                 div_start;
    logic [WORD_BITS-1:0] div_dividend;
    logic                 div_done;
    logic [WORD_BITS-1:0] div_quo;
    radix_t               div_rem;

    logic  st_wr, st_rd;
    char_t st_rd_data;

    itrs_div #(.WORD_BITS(WORD_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (eff_radix(radix_reg)),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    itrs_digit_stack #(.DEPTH(WORD_BITS)) u_stack (
        .clk     (clk),
        .wr_en   (st_wr),
        .wr_addr (nd_reg[AW-1:0]),
        .wr_data (digit_char(div_rem)),
        .rd_en   (st_rd),
        .rd_addr (nd_dec[AW-1:0]),
        .rd_data (st_rd_data)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = oval_reg;
    assign m_axis_tdata  = ochar_reg;
    assign m_axis_tlast  = olast_reg;

    always_comb
    begin
        raw      = WORD_BITS'(signed'(s_axis_tdata));
        mag      = raw[WORD_BITS-1] ? (~raw + 1'b1) : raw;
        nd_inc   = nd_reg + 1'b1;
        nd_dec   = nd_reg - 1'b1;
        out_free = !oval_reg || m_axis_tready;

        state_next   = state_reg;
        radix_next   = radix_reg;
        neg_next     = neg_reg;
        nd_next      = nd_reg;
        oval_next    = oval_reg && !m_axis_tready;
        ochar_next   = ochar_reg;
        olast_next   = olast_reg;
        div_start    = 1'b0;
        div_dividend = mag;
        st_wr        = 1'b0;
        st_rd        = 1'b0;

        if (cfg_valid)
        begin
            radix_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    neg_next   = raw[WORD_BITS-1];
                    nd_next    = '0;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    st_wr   = 1'b1;
                    nd_next = nd_inc;
                    if ((div_quo != '0) && (nd_inc < NW'(WORD_BITS)))
                    begin
                        div_start    = 1'b1;
                        div_dividend = div_quo;
                    end
                    else if (neg_reg)
                    begin
                        state_next = ST_SIGN;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    ochar_next = MINUS_SIGN;
                    olast_next = 1'b0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                st_rd      = 1'b1;
                nd_next    = nd_dec;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    ochar_next = st_rd_data;
                    olast_next = (nd_reg == '0);
                    state_next = (nd_reg == '0) ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            radix_reg <= RADIX_RESET;
            oval_reg  <= 1'b0;
            nd_reg    <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            radix_reg <= radix_next;
            oval_reg  <= oval_next;
            nd_reg    <= nd_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

endmodule

@@ tb/itrs_checker.sv @@
// Checker for the radix string converter: predicts characters and compares the output stream.
module itrs_checker
    import itrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [5:0]  cfg_data,      // radix
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // value
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,  // character
    input  logic        m_axis_tlast,
    output int          error_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        char_t ch;
        logic  last;
    } char_rec_t;

    radix_t    radix_shadow;
    char_rec_t expected_chars[$];

    function automatic void predict_chars(input logic [31:0] value, input radix_t reg_radix);
        logic [31:0] mag;
        logic [31:0] base;
        logic [31:0] rem;
        char_t       digit_buf[0:31];
        char_rec_t   rec;
        int          nd;
        if (reg_radix < RADIX_MIN)
        begin
            base = {26'd0, RADIX_MIN};
        end
        else if (reg_radix > RADIX_MAX)
        begin
            base = {26'd0, RADIX_MAX};
        end
        else
        begin
            base = {26'd0, reg_radix};
        end
        mag = value[31] ? (~value + 32'd1) : value;
        nd = 0;
        do
        begin
            rem = mag % base;
            if (rem < {26'd0, DECIMAL_LIMIT})
            begin
                digit_buf[nd] = rem[7:0] + DIGIT_ZERO;
            end
            else
            begin
                digit_buf[nd] = rem[7:0] + LETTER_OFFSET;
            end
            nd++;
            mag = mag / base;
        end
        while (mag != 32'd0 && nd < 32);
        if (value[31])
        begin
            rec.ch = MINUS_SIGN;
            rec.last = 1'b0;
            expected_chars.push_back(rec);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            rec.ch = digit_buf[k];
            rec.last = (k == 0);
            expected_chars.push_back(rec);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        char_rec_t want;
        if (!rst_n)
        begin
            radix_shadow <= RADIX_RESET;
            expected_chars.delete();
            error_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character transaction: character 0x%02h, last %0b",
                           m_axis_tdata, m_axis_tlast);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last)
                    begin
                        error_count <= error_count + 1;
                    end
                    if (m_axis_tdata !== want.ch)
                    begin
                        $error("character mismatch: expected 0x%02h, actual 0x%02h",
                               want.ch, m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last mismatch: expected %0b, actual %0b",
                               want.last, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_chars(s_axis_tdata, radix_shadow);
            end
            if (cfg_valid && cfg_ready)
            begin
                radix_shadow <= cfg_data;
            end
            pending_count <= expected_chars.size();
        end
    end

endmodule

@@ tb/int_to_radix_string_tb.sv @@
// Top of the radix string converter testbench: clock, reset, stimulus and verdict.
module int_to_radix_string_tb;
    import itrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    int          error_count;
    int          pending_count;

    always #10 clk = ~clk;

    int_to_radix_string dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    itrs_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    task automatic send_value(input logic [31:0] value);
        int sel;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sel = $urandom_range(0, 9);
        if (sel < 5)
        begin
            gap = 0;
        end
        else if (sel < 9)
        begin
            gap = $urandom_range(1, 4);
        end
        else
        begin
            gap = $urandom_range(50, 300);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_radix(input radix_t new_radix);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= new_radix;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        int          sel;
        logic [31:0] v;
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            v = $urandom;
        end
        else if (sel < 6)
        begin
            v = $urandom_range(0, 40);
        end
        else if (sel < 8)
        begin
            v = -$urandom_range(1, 40);
        end
        else if (sel == 8)
        begin
            case ($urandom_range(0, 3))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'h0000_0000;
                default: v = 32'hffff_ffff;
            endcase
        end
        else
        begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1)
            begin
                v = -v;
            end
        end
        return v;
    endfunction

    function automatic radix_t pick_radix();
        radix_t r;
        if ($urandom_range(0, 7) == 0)
        begin
            r = radix_t'($urandom_range(0, 63));
        end
        else
        begin
            r = radix_t'($urandom_range(2, 36));
        end
        return r;
    endfunction

    initial
    begin
        int run_len;
        int sel;
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            sel = $urandom_range(0, 15);
            if (sel == 0)
            begin
                m_axis_tready <= 1'b1;
                run_len = $urandom_range(300, 2000);
            end
            else if (sel < 3)
            begin
                m_axis_tready <= 1'b0;
                run_len = $urandom_range(20, 60);
            end
            else if (sel < 9)
            begin
                m_axis_tready <= 1'b0;
                run_len = $urandom_range(1, 3);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                run_len = $urandom_range(1, 6);
            end
            repeat (run_len) @(posedge clk);
        end
    end

    initial
    begin
        #60_000_000;
        $display("int_to_radix_string test failed");
        $finish;
    end

    initial
    begin
        int phase_len;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hffff_ffff);
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(32'd123456789);

        write_radix(6'd2);
        send_value(32'h8000_0000);
        send_value(32'hffff_ffff);
        send_value(32'h7fff_ffff);

        write_radix(RADIX_MAX);
        send_value(32'd35);
        send_value(-32'sd36);
        send_value(32'h8000_0000);

        write_radix(6'd16);
        send_value(32'hdead_beef);
        send_value(32'd255);

        write_radix(6'd0);
        send_value(32'd6);
        write_radix(6'd1);
        send_value(-32'sd3);
        write_radix(6'd63);
        send_value(32'd35);
        send_value(32'd36);
        write_radix(6'd37);
        send_value(32'd71);
        write_radix(6'd8);
        send_value(-32'sd8);

        for (int phase = 0; phase < 10; phase++)
        begin
            write_radix(pick_radix());
            phase_len = $urandom_range(5, 11);
            for (int i = 0; i < phase_len; i++)
            begin
                send_value(pick_value());
                if ($urandom_range(0, 9) == 0)
                begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (error_count == 0)
        begin
            $display("int_to_radix_string test passed");
        end
        else
        begin
            $display("int_to_radix_string test failed");
        end
        $finish;
    end

endmodule
